@@ sv/rffd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rffd_pkg
// Shared types and codes for the radio frame field deframer.
// ----------------------------------------------------------------------------
package rffd_pkg;

   // word classes produced by the front end
   localparam logic [1:0] CLS_DATA     = 2'd0;
   localparam logic [1:0] CLS_SIGNAL   = 2'd1;
   localparam logic [1:0] CLS_END      = 2'd2;
   localparam logic [1:0] CLS_LINE_ERR = 2'd3;

   // input kinds
   localparam logic [3:0] KIND_DATA       = 4'd0;
   localparam logic [3:0] KIND_SIGNAL     = 4'd1;
   localparam logic [3:0] KIND_END        = 4'd2;
   localparam logic [3:0] KIND_BAD_START  = 4'd3;
   localparam logic [3:0] KIND_BAD_STOP   = 4'd4;
   localparam logic [3:0] KIND_UNEXP_STRT = 4'd5;
   localparam logic [3:0] KIND_UNEXP_END  = 4'd6;
   localparam logic [3:0] KIND_MANCHESTER = 4'd7;

   // event codes
   localparam logic [2:0] EV_HEADER = 3'd0;
   localparam logic [2:0] EV_ADDR   = 3'd1;
   localparam logic [2:0] EV_CMD    = 3'd2;
   localparam logic [2:0] EV_LEN    = 3'd3;
   localparam logic [2:0] EV_BYTE   = 3'd4;
   localparam logic [2:0] EV_GOOD   = 3'd5;
   localparam logic [2:0] EV_ERROR  = 3'd6;
   localparam logic [2:0] EV_CLOSED = 3'd7;

   // error codes
   localparam logic [2:0] ERR_START_BIT  = 3'd0;
   localparam logic [2:0] ERR_STOP_BIT   = 3'd1;
   localparam logic [2:0] ERR_UNEXP_STRT = 3'd2;
   localparam logic [2:0] ERR_UNEXP_END  = 3'd3;
   localparam logic [2:0] ERR_MANCHESTER = 3'd4;
   localparam logic [2:0] ERR_PREMATURE  = 3'd5;
   localparam logic [2:0] ERR_EXTRA_DATA = 3'd6;
   localparam logic [2:0] ERR_CHECKSUM   = 3'd7;

   // header flag bits
   localparam logic [6:0] FLAG_INFO    = 7'h20;
   localparam logic [6:0] FLAG_REQUEST = 7'h08;
   localparam logic [6:0] FLAG_RESP    = 7'h10;

   localparam logic [1:0] MSG_INFO     = 2'd0;
   localparam logic [1:0] MSG_REQUEST  = 2'd1;
   localparam logic [1:0] MSG_RESPONSE = 2'd2;
   localparam logic [1:0] MSG_WRITE    = 2'd3;

   typedef struct packed {
      logic [1:0] cls;
      logic [2:0] code;
      logic [7:0] byte_value;
   } item_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [1:0]  msg_type;
      logic [2:0]  addr_mask;
      logic [1:0]  param_mask;
      logic [7:0]  signal_level;
      logic [1:0]  slot;
      logic [23:0] value;
      logic [2:0]  error_code;
   } rsp_type;

   // header bits 5..2 to message flags (low three bits: addresses present)
   function automatic logic [6:0] type_flags(input logic [3:0] sel);
      logic [6:0] f;
      case (sel)
         4'h0:    f = 7'h0F;
         4'h1:    f = 7'h0C;
         4'h2:    f = 7'h0D;
         4'h3:    f = 7'h0B;
         4'h4:    f = 7'h27;
         4'h5:    f = 7'h24;
         4'h6:    f = 7'h25;
         4'h7:    f = 7'h23;
         4'h8:    f = 7'h47;
         4'h9:    f = 7'h44;
         4'hA:    f = 7'h45;
         4'hB:    f = 7'h43;
         4'hC:    f = 7'h17;
         4'hD:    f = 7'h14;
         4'hE:    f = 7'h15;
         default: f = 7'h13;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

@@ sv/rffd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rffd_front
// Classifies each incoming word into data, signal strength, end or line error.
// ----------------------------------------------------------------------------
module rffd_front import rffd_pkg::*; (
   input  wire logic [3:0] req_kind,
   input  wire logic [7:0] req_byte_value,
   output item_type        item
);

   always_comb begin
      item.byte_value = req_byte_value;
      item.cls        = CLS_LINE_ERR;
      item.code       = ERR_PREMATURE;
      case (req_kind)
         KIND_DATA:       item.cls  = CLS_DATA;
         KIND_SIGNAL:     item.cls  = CLS_SIGNAL;
         KIND_END:        item.cls  = CLS_END;
         KIND_BAD_START:  item.code = ERR_START_BIT;
         KIND_BAD_STOP:   item.code = ERR_STOP_BIT;
         KIND_UNEXP_STRT: item.code = ERR_UNEXP_STRT;
         KIND_UNEXP_END:  item.code = ERR_UNEXP_END;
         KIND_MANCHESTER: item.code = ERR_MANCHESTER;
         default:         item.code = ERR_PREMATURE;
      endcase
   end

endmodule
`default_nettype wire

@@ sv/rffd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rffd_queue
// Small fifo of classified words between the front end and the parser.
// ----------------------------------------------------------------------------
module rffd_queue import rffd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

@@ sv/rffd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rffd_back
// Frame parser: walks the frame fields one word a cycle unless stalled, and registers events.
// ----------------------------------------------------------------------------
module rffd_back import rffd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_valid,
   output logic          item_ready,
   input  wire item_type item,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp
);

   localparam logic [3:0] PH_HEADER  = 4'd0;
   localparam logic [3:0] PH_ADDR0   = 4'd1;
   localparam logic [3:0] PH_ADDR2   = 4'd3;
   localparam logic [3:0] PH_PARAM0  = 4'd4;
   localparam logic [3:0] PH_PARAM1  = 4'd5;
   localparam logic [3:0] PH_CMD     = 4'd6;
   localparam logic [3:0] PH_LEN     = 4'd7;
   localparam logic [3:0] PH_PAYLOAD = 4'd8;
   localparam logic [3:0] PH_CHECK   = 4'd9;
   localparam logic [3:0] PH_DONE    = 4'd10;
   localparam logic [3:0] PH_ERROR   = 4'd11;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  header_ff, header_in;
   logic [23:0] accum_ff, accum_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  signal_ff, signal_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        pop;
   logic        fire;
   rsp_type     res;
   logic [6:0]  flags;
   logic [6:0]  hdr_flags;
   logic [3:0]  eff;
   logic [1:0]  slot_idx;
   logic [7:0]  sum_next;
   logic [7:0]  count_next;
   logic [23:0] addr_next;
   logic [15:0] cmd_next;
   logic [7:0]  b;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;
   assign b          = item.byte_value;
   assign flags      = type_flags(header_ff[5:2]);
   assign hdr_flags  = type_flags(b[5:2]);
   assign sum_next   = sum_ff + b;
   assign count_next = count_ff + 1'b1;
   assign addr_next  = {accum_ff[15:0], b};
   assign cmd_next   = {accum_ff[7:0], b};

   // resolve the field this data word lands in, skipping absent sections
   always_comb begin
      eff = phase_ff;
      for (int i = 0; i < 3; i++) begin
         if (eff inside {[PH_ADDR0:PH_ADDR2]} && !flags[2'(eff - PH_ADDR0)]) begin
            eff = eff + 1'b1;
         end
      end
      if (eff == PH_PARAM0 && !header_ff[1]) begin
         eff = PH_PARAM1;
      end
      if (eff == PH_PARAM1 && !header_ff[0]) begin
         eff = PH_CMD;
      end
      if (eff == PH_PAYLOAD && count_ff == '0) begin
         eff = PH_CHECK;
      end
   end

   assign slot_idx = 2'(eff - PH_ADDR0);

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      header_in = header_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      signal_in = signal_ff;
      res       = '0;
      fire      = 1'b0;
      if (pop) begin
         case (item.cls)
            CLS_SIGNAL: begin
               signal_in = b;
            end
            default: begin
               if (phase_ff == PH_ERROR) begin
                  if (item.cls == CLS_END) begin
                     phase_in      = PH_HEADER;
                     res.event_res = EV_CLOSED;
                     fire          = 1'b1;
                  end
               end else if (item.cls != CLS_DATA) begin
                  fire = 1'b1;
                  if (phase_ff == PH_DONE && item.cls == CLS_END) begin
                     phase_in      = PH_HEADER;
                     res.event_res = EV_CLOSED;
                  end else begin
                     phase_in       = PH_ERROR;
                     res.event_res  = EV_ERROR;
                     res.error_code = item.code;
                  end
               end else if (phase_ff == PH_DONE) begin
                  fire           = 1'b1;
                  phase_in       = PH_ERROR;
                  res.event_res  = EV_ERROR;
                  res.error_code = ERR_EXTRA_DATA;
               end else if (phase_ff == PH_HEADER) begin
                  fire             = 1'b1;
                  sum_in           = b;
                  header_in        = b;
                  phase_in         = PH_ADDR0;
                  count_in         = '0;
                  accum_in         = '0;
                  res.event_res    = EV_HEADER;
                  res.addr_mask    = hdr_flags[2:0];
                  res.param_mask   = b[1:0];
                  res.signal_level = signal_ff;
                  if ((hdr_flags & FLAG_INFO) != '0) begin
                     res.msg_type = MSG_INFO;
                  end else if ((hdr_flags & FLAG_REQUEST) != '0) begin
                     res.msg_type = MSG_REQUEST;
                  end else if ((hdr_flags & FLAG_RESP) != '0) begin
                     res.msg_type = MSG_RESPONSE;
                  end else begin
                     res.msg_type = MSG_WRITE;
                  end
               end else begin
                  sum_in   = sum_next;
                  phase_in = eff;
                  if (eff inside {[PH_ADDR0:PH_ADDR2]}) begin
                     accum_in = addr_next;
                     count_in = count_next;
                     if (count_next == 8'd3) begin
                        fire          = 1'b1;
                        res.event_res = EV_ADDR;
                        res.slot      = slot_idx;
                        res.value     = addr_next;
                        phase_in      = eff + 1'b1;
                        count_in      = '0;
                        accum_in      = '0;
                     end
                  end else if (eff == PH_PARAM0) begin
                     phase_in = PH_PARAM1;
                  end else if (eff == PH_PARAM1) begin
                     phase_in = PH_CMD;
                  end else if (eff == PH_CMD) begin
                     accum_in = {8'd0, cmd_next};
                     count_in = count_next;
                     if (count_next == 8'd2) begin
                        fire          = 1'b1;
                        res.event_res = EV_CMD;
                        res.value     = {8'd0, cmd_next};
                        phase_in      = PH_LEN;
                        count_in      = '0;
                        accum_in      = '0;
                     end
                  end else if (eff == PH_LEN) begin
                     fire          = 1'b1;
                     count_in      = b;
                     phase_in      = PH_PAYLOAD;
                     res.event_res = EV_LEN;
                     res.value     = {16'd0, b};
                  end else if (eff == PH_PAYLOAD) begin
                     fire          = 1'b1;
                     count_in      = count_ff - 1'b1;
                     res.event_res = EV_BYTE;
                     res.value     = {16'd0, b};
                  end else begin
                     // checksum word: the whole frame must sum to zero
                     fire = 1'b1;
                     if (sum_next != '0) begin
                        phase_in       = PH_ERROR;
                        res.event_res  = EV_ERROR;
                        res.error_code = ERR_CHECKSUM;
                     end else begin
                        phase_in      = PH_DONE;
                        res.event_res = EV_GOOD;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (item_ready) begin
         rsp_valid_in = fire;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         sum_ff       <= '0;
         header_ff    <= '0;
         accum_ff     <= '0;
         count_ff     <= '0;
         signal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         header_ff    <= header_in;
         accum_ff     <= accum_in;
         count_ff     <= count_in;
         signal_ff    <= signal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

@@ sv/radio_frame_field_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_frame_field_deframer
// Parses decoded radio words into header, address, command, length, payload,
// frame good, error and frame closed events.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_ready is high and gives at most one event
// per word. A front end classifies each word and pushes it into a
// QUEUE_DEPTH-entry fifo; the parser behind it handles one word per clock
// unless its held event is stalled, and registers its event in an output
// register, so a word passes a fifo entry and its event the output register.
// Throughput stays at one word per clock while rsp_ready is high. When the
// result side stalls, the fifo absorbs up to QUEUE_DEPTH words before req_ready
// drops. After any error, words are dropped until an end of frame.
// ----------------------------------------------------------------------------
module radio_frame_field_deframer import rffd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_kind,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [1:0]       rsp_msg_type,
   output logic [2:0]       rsp_addr_mask,
   output logic [1:0]       rsp_param_mask,
   output logic [7:0]       rsp_signal_level,
   output logic [1:0]       rsp_slot,
   output logic [23:0]      rsp_value,
   output logic [2:0]       rsp_error_code
);

   item_type front_item;
   item_type head_item;
   logic     head_valid;
   logic     head_ready;
   rsp_type  rsp;

   rffd_front u_front (
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .item           (front_item)
   );

   rffd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (front_item),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_item  (head_item)
   );

   rffd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item_ready (head_ready),
      .item       (head_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_event_res    = rsp.event_res;
   assign rsp_msg_type     = rsp.msg_type;
   assign rsp_addr_mask    = rsp.addr_mask;
   assign rsp_param_mask   = rsp.param_mask;
   assign rsp_signal_level = rsp.signal_level;
   assign rsp_slot         = rsp.slot;
   assign rsp_value        = rsp.value;
   assign rsp_error_code   = rsp.error_code;

   // header fields only travel with a header event
   a_header_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_HEADER |->
         rsp_msg_type == '0 && rsp_addr_mask == '0 && rsp_param_mask == '0 &&
         rsp_signal_level == '0)
      else $error("header fields set on a non-header event");

   a_error_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_ERROR |-> rsp_error_code == '0)
      else $error("error code set on a non-error event");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_ADDR |-> rsp_slot != 2'd3)
      else $error("address slot out of range");

   // events without a value field carry zero there
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_HEADER || rsp_event_res == EV_GOOD ||
                    rsp_event_res == EV_ERROR || rsp_event_res == EV_CLOSED)
         |-> rsp_value == '0)
      else $error("value set on an event without one");

endmodule
`default_nettype wire

@@ test/tb_radio_frame_field_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radio_frame_field_deframer
// Self-checking bench for the radio frame deframer: a short table of directed
// words, then random frames (good, bad checksum, cut short, line errors, extra
// data, noise) with signal-strength words mixed in. Every accepted word goes
// through a frame parser model in the bench and each event is compared field
// by field. Both handshakes stall at random, with one long result-side hold.
// ----------------------------------------------------------------------------
module tb_radio_frame_field_deframer;
   import rffd_pkg::*;

   localparam int RANDOM_WORDS  = 900;
   localparam int HOLD_CYCLES   = 80;
   localparam int IDLE_LIMIT    = 1000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int PAUSE_EVERY   = 20;
   localparam int HOLD_FRAME    = 6;

   localparam logic [3:0] KIND_UNLISTED  = 4'd15;
   localparam logic [2:0] UNTYPED        = 3'd0;

   // header bits 5..2 to message flags
   localparam logic [6:0] FLAG_TABLE [16] = '{
      7'h0F, 7'h0C, 7'h0D, 7'h0B,
      7'h27, 7'h24, 7'h25, 7'h23,
      7'h47, 7'h44, 7'h45, 7'h43,
      7'h17, 7'h14, 7'h15, 7'h13
   };

   typedef enum logic [3:0] {
      ST_HEADER, ST_ADDR0, ST_ADDR1, ST_ADDR2, ST_PARAM0, ST_PARAM1,
      ST_CMD, ST_LEN, ST_PAYLOAD, ST_CHECK, ST_DONE, ST_ERROR
   } parse_state_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] val;
      logic       given;
      logic [2:0] ev;
      logic [2:0] code;
   } stim_row_type;

   typedef struct packed {
      logic    given;
      rsp_type ev;
   } typed_note_type;

   // frame starting from reset, extremes, then a few line error kinds
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{KIND_END,        8'h00, 1'b1, EV_ERROR,  ERR_PREMATURE},
      '{KIND_DATA,       8'hAA, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_SIGNAL,     8'hFF, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_END,        8'h00, 1'b1, EV_CLOSED, UNTYPED},
      '{KIND_DATA,       8'hC7, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'hFF, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'hFF, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'hFF, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'h00, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'h00, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'hFF, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'hFF, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'h01, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'h80, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_DATA,       8'hBD, 1'b1, EV_GOOD,   UNTYPED},
      '{KIND_DATA,       8'h00, 1'b1, EV_ERROR,  ERR_EXTRA_DATA},
      '{KIND_END,        8'h00, 1'b1, EV_CLOSED, UNTYPED},
      '{KIND_DATA,       8'h00, 1'b0, UNTYPED,   UNTYPED},
      '{KIND_BAD_STOP,   8'h00, 1'b1, EV_ERROR,  ERR_STOP_BIT},
      '{KIND_END,        8'h00, 1'b1, EV_CLOSED, UNTYPED},
      '{KIND_MANCHESTER, 8'h5A, 1'b1, EV_ERROR,  ERR_MANCHESTER},
      '{KIND_END,        8'h00, 1'b1, EV_CLOSED, UNTYPED},
      '{KIND_UNLISTED,   8'hFF, 1'b1, EV_ERROR,  ERR_PREMATURE},
      '{KIND_END,        8'h00, 1'b1, EV_CLOSED, UNTYPED}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_kind = '0;
   logic [7:0]  req_byte_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [1:0]  rsp_msg_type;
   logic [2:0]  rsp_addr_mask;
   logic [1:0]  rsp_param_mask;
   logic [7:0]  rsp_signal_level;
   logic [1:0]  rsp_slot;
   logic [23:0] rsp_value;
   logic [2:0]  rsp_error_code;

   radio_frame_field_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_msg_type     (rsp_msg_type),
      .rsp_addr_mask    (rsp_addr_mask),
      .rsp_param_mask   (rsp_param_mask),
      .rsp_signal_level (rsp_signal_level),
      .rsp_slot         (rsp_slot),
      .rsp_value        (rsp_value),
      .rsp_error_code   (rsp_error_code)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // parser model state
   parse_state_type parse_state = ST_HEADER;
   logic [7:0]      frame_sum   = '0;
   logic [7:0]      frame_hdr   = '0;
   logic [23:0]     field_acc   = '0;
   logic [7:0]      field_bytes = '0;
   logic [7:0]      last_level  = '0;

   rsp_type        pending_events [$];
   typed_note_type word_notes [$];

   int  failures = 0;
   int  events_checked = 0;
   int  good_frames = 0;
   int  error_events = 0;
   int  words_parsed = 0;
   int  frames_sent = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_off_request = 1'b0;
   bit  hold_active = 1'b0;

   function automatic rsp_type error_event(input logic [2:0] code);
      rsp_type ev;
      ev = '0;
      ev.event_res = EV_ERROR;
      ev.error_code = code;
      parse_state = ST_ERROR;
      return ev;
   endfunction

   // advances the parser model by one word; returns 1 when an event results
   function automatic bit frame_step(input logic [3:0] kind, input logic [7:0] b,
                                     output rsp_type ev);
      logic [6:0] flags;
      logic [1:0] slot;
      ev = '0;
      if (kind == KIND_SIGNAL) begin
         last_level = b;
         return 1'b0;
      end
      if (parse_state == ST_ERROR) begin
         if (kind != KIND_END)
            return 1'b0;
         parse_state = ST_HEADER;
         ev.event_res = EV_CLOSED;
         return 1'b1;
      end
      if (kind != KIND_DATA) begin
         if (parse_state == ST_DONE && kind == KIND_END) begin
            parse_state = ST_HEADER;
            ev.event_res = EV_CLOSED;
            return 1'b1;
         end
         case (kind)
            KIND_BAD_START:  ev = error_event(ERR_START_BIT);
            KIND_BAD_STOP:   ev = error_event(ERR_STOP_BIT);
            KIND_UNEXP_STRT: ev = error_event(ERR_UNEXP_STRT);
            KIND_UNEXP_END:  ev = error_event(ERR_UNEXP_END);
            KIND_MANCHESTER: ev = error_event(ERR_MANCHESTER);
            default:         ev = error_event(ERR_PREMATURE);
         endcase
         return 1'b1;
      end
      if (parse_state == ST_DONE) begin
         ev = error_event(ERR_EXTRA_DATA);
         return 1'b1;
      end
      if (parse_state == ST_HEADER) begin
         frame_sum = b;
         frame_hdr = b;
         flags = FLAG_TABLE[b[5:2]];
         parse_state = ST_ADDR0;
         field_bytes = '0;
         field_acc = '0;
         ev.event_res = EV_HEADER;
         if ((flags & FLAG_INFO) != 0)         ev.msg_type = MSG_INFO;
         else if ((flags & FLAG_REQUEST) != 0) ev.msg_type = MSG_REQUEST;
         else if ((flags & FLAG_RESP) != 0)    ev.msg_type = MSG_RESPONSE;
         else                                  ev.msg_type = MSG_WRITE;
         ev.addr_mask = flags[2:0];
         ev.param_mask = b[1:0];
         ev.signal_level = last_level;
         return 1'b1;
      end

      frame_sum = frame_sum + b;
      flags = FLAG_TABLE[frame_hdr[5:2]];
      // absent addresses are skipped without taking the byte
      while (parse_state >= ST_ADDR0 && parse_state <= ST_ADDR2) begin
         slot = 2'(parse_state - ST_ADDR0);
         if (flags[slot]) begin
            field_acc = {field_acc[15:0], b};
            field_bytes = field_bytes + 8'd1;
            if (field_bytes != 8'd3)
               return 1'b0;
            ev.event_res = EV_ADDR;
            ev.slot = slot;
            ev.value = field_acc;
            parse_state = parse_state_type'(parse_state + 1);
            field_bytes = '0;
            field_acc = '0;
            return 1'b1;
         end
         parse_state = parse_state_type'(parse_state + 1);
      end
      if (parse_state == ST_PARAM0) begin
         parse_state = ST_PARAM1;
         if (frame_hdr[1])
            return 1'b0;
      end
      if (parse_state == ST_PARAM1) begin
         parse_state = ST_CMD;
         if (frame_hdr[0])
            return 1'b0;
      end
      if (parse_state == ST_CMD) begin
         field_acc = {8'h00, field_acc[7:0], b};
         field_bytes = field_bytes + 8'd1;
         if (field_bytes != 8'd2)
            return 1'b0;
         ev.event_res = EV_CMD;
         ev.value = field_acc;
         parse_state = ST_LEN;
         field_bytes = '0;
         field_acc = '0;
         return 1'b1;
      end
      if (parse_state == ST_LEN) begin
         field_bytes = b;
         parse_state = ST_PAYLOAD;
         ev.event_res = EV_LEN;
         ev.value = {16'd0, b};
         return 1'b1;
      end
      if (parse_state == ST_PAYLOAD) begin
         if (field_bytes != 8'd0) begin
            field_bytes = field_bytes - 8'd1;
            ev.event_res = EV_BYTE;
            ev.value = {16'd0, b};
            return 1'b1;
         end
         parse_state = ST_CHECK;
      end
      if (parse_state == ST_CHECK) begin
         if (frame_sum != 8'd0) begin
            ev = error_event(ERR_CHECKSUM);
            return 1'b1;
         end
         parse_state = ST_DONE;
         ev.event_res = EV_GOOD;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet || hold_active)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic stim_row_type plain_row(input logic [3:0] kind,
                                              input logic [7:0] val);
      stim_row_type row;
      row = '{kind, val, 1'b0, UNTYPED, UNTYPED};
      return row;
   endfunction

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic send_word(input stim_row_type row);
      typed_note_type note;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note = '0;
      note.given = row.given;
      note.ev.event_res = row.ev;
      note.ev.error_code = row.code;
      word_notes.push_back(note);
      req_valid <= 1'b1;
      req_kind <= row.kind;
      req_byte_value <= row.val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // one random frame: good, bad checksum, cut short, line error, extra data or noise
   task automatic send_frame();
      logic [7:0]   body [$];
      stim_row_type words [$];
      logic [7:0]   hdr;
      logic [7:0]   total;
      logic [6:0]   flags;
      int           len, r, cut;
      hdr = 8'($urandom_range(0, 255));
      flags = FLAG_TABLE[hdr[5:2]];
      body.push_back(hdr);
      for (int s = 0; s < 3; s++)
         if (flags[s])
            repeat (3) body.push_back(8'($urandom_range(0, 255)));
      if (hdr[1]) body.push_back(8'($urandom_range(0, 255)));
      if (hdr[0]) body.push_back(8'($urandom_range(0, 255)));
      repeat (2) body.push_back(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(0, 4);
      else if (r < 97) len = $urandom_range(5, 24);
      else if (r < 99) len = $urandom_range(25, 64);
      else             len = 255;
      body.push_back(8'(len));
      repeat (len) body.push_back(8'($urandom_range(0, 255)));
      total = '0;
      foreach (body[i]) total = total + body[i];
      body.push_back(8'(-total));

      r = $urandom_range(0, 99);
      if (r < 8)
         body[body.size() - 1] = body[body.size() - 1] ^ 8'($urandom_range(1, 255));
      if (r >= 8 && r < 16) begin
         cut = $urandom_range(1, body.size() - 1);
         body = body[0:cut - 1];
      end
      cut = (r >= 16 && r < 24) ? $urandom_range(0, body.size()) : body.size();
      for (int i = 0; i < cut; i++)
         words.push_back(plain_row(KIND_DATA, body[i]));
      if (r >= 16 && r < 24) begin
         // line error, then random words that the error state drops until an end word
         words.push_back(plain_row(4'($urandom_range(KIND_BAD_START, KIND_UNLISTED)),
                                   8'($urandom_range(0, 255))));
         repeat ($urandom_range(0, 2))
            words.push_back(plain_row(4'($urandom_range(0, 15)),
                                      8'($urandom_range(0, 255))));
      end else if (r >= 24 && r < 30) begin
         repeat ($urandom_range(1, 3))
            words.push_back(plain_row(KIND_DATA, 8'($urandom_range(0, 255))));
      end else if (r >= 30 && r < 35) begin
         words.delete();
         repeat ($urandom_range(1, 8))
            words.push_back(plain_row(4'($urandom_range(0, 15)),
                                      8'($urandom_range(0, 255))));
      end
      words.push_back(plain_row(KIND_END, 8'($urandom_range(0, 255))));

      foreach (words[i]) begin
         if ($urandom_range(0, 11) == 0)
            send_word(plain_row(KIND_SIGNAL, 8'($urandom_range(0, 255))));
         send_word(words[i]);
      end
      frames_sent++;
   endtask

   // stimulus
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i])
         send_word(DIRECTED_ROWS[i]);
      wait_for_events();
      while (words_parsed < RANDOM_WORDS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (frames_sent == HOLD_FRAME)
            hold_off_request = 1'b1;
         send_frame();
         if (frames_sent % PAUSE_EVERY == 0)
            wait_for_events();
      end
      wait_for_events();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d frames, %0d parsed words, %0d events checked", frames_sent,
               words_parsed, events_checked);
      $display("%0d good frames and %0d error events among them", good_frames,
               error_events);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side stalls, with one long hold while words keep coming
   initial begin : result_sink
      int stall;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : scoreboard
      typed_note_type note;
      rsp_type        predicted;
      rsp_type        want;
      bit             produced;
      if (!reset) begin
         if (req_valid && req_ready) begin
            note = '0;
            if (word_notes.size() != 0)
               note = word_notes.pop_front();
            if (req_kind != KIND_SIGNAL && (parse_state != ST_ERROR || req_kind == KIND_END))
               words_parsed++;
            produced = frame_step(req_kind, req_byte_value, predicted);
            if (note.given)
               pending_events.push_back(note.ev);
            else if (produced)
               pending_events.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               failures++;
               $display("%0t ns: expected no event, got event %0d", $time, rsp_event_res);
            end else begin
               want = pending_events.pop_front();
               check_field("event_res", 24'(want.event_res), 24'(rsp_event_res));
               check_field("msg_type", 24'(want.msg_type), 24'(rsp_msg_type));
               check_field("addr_mask", 24'(want.addr_mask), 24'(rsp_addr_mask));
               check_field("param_mask", 24'(want.param_mask), 24'(rsp_param_mask));
               check_field("signal_level", 24'(want.signal_level),
                           24'(rsp_signal_level));
               check_field("slot", 24'(want.slot), 24'(rsp_slot));
               check_field("value", want.value, rsp_value);
               check_field("error_code", 24'(want.error_code), 24'(rsp_error_code));
               events_checked++;
               if (want.event_res == EV_GOOD) good_frames++;
               if (want.event_res == EV_ERROR) error_events++;
            end
         end
      end
   end

   // ends the run when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
